@@ rtl/rwsbf_pkg.sv @@
`timescale 1ns / 1ps
package rwsbf_pkg;

  localparam int FRAME_CAPACITY = 8192;
  localparam int FB_W = $clog2(FRAME_CAPACITY + 8);
  localparam logic [FB_W-1:0] FB_LIMIT     = FB_W'(FRAME_CAPACITY - 6);
  localparam logic [FB_W-1:0] FB_OPEN_ADD  = FB_W'(8);
  localparam logic [FB_W-1:0] FB_WRITE_ADD = FB_W'(6);

  localparam logic [7:0] CMD_SEL_BANK0 = 8'he1;
  localparam logic [7:0] CMD_VAL_BANK0 = 8'he3;
  localparam logic [7:0] CMD_SEL_BANK1 = 8'he5;
  localparam logic [7:0] CMD_VAL_BANK1 = 8'he7;
  localparam logic [7:0] CMD_DATA      = 8'hfb;
  localparam logic [7:0] LINE_START    = 8'h00;
  localparam logic [7:0] LINE_END      = 8'h02;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_REGISTER = 2'd1;
  localparam logic [7:0] DEVICE_ADDRESS_RST  = 8'd66;
  localparam logic [7:0] DEVICE_REGISTER_RST = 8'd18;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int CMD_IDX_W = 3;
  localparam logic [CMD_IDX_W-1:0] CMD_HDR_ADDR  = 3'd0;
  localparam logic [CMD_IDX_W-1:0] CMD_HDR_REG   = 3'd1;
  localparam logic [CMD_IDX_W-1:0] CMD_SEL       = 3'd2;
  localparam logic [CMD_IDX_W-1:0] CMD_REG       = 3'd3;
  localparam logic [CMD_IDX_W-1:0] CMD_VAL_SEL   = 3'd4;
  localparam logic [CMD_IDX_W-1:0] CMD_VAL       = 3'd5;
  localparam logic [CMD_IDX_W-1:0] CMD_DATA_SEL  = 3'd6;
  localparam logic [CMD_IDX_W-1:0] CMD_DATA_VAL  = 3'd7;

  localparam logic [2:0] LC_FULL = 3'd6;

  // close: end the open frame first; open: start byte and header.
  // close without open is a flush.
  typedef struct packed {
    logic       close;
    logic       open;
    logic       bank;
    logic [7:0] reg_index;
    logic [7:0] value;
    logic [7:0] hdr_addr;
    logic [7:0] hdr_reg;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CLOSE_LO,
    B_CLOSE_END,
    B_START,
    B_CMD,
    B_CMD2
  } back_state_t;

  function automatic logic [7:0] line_byte(input logic [6:0] grp);
    line_byte = {grp, 1'b1};
  endfunction

endpackage

@@ rtl/rwsbf_front.sv @@
`timescale 1ns / 1ps
module rwsbf_front import rwsbf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_command,
  input  logic                 in_bank,
  input  logic [7:0]           in_reg_index,
  input  logic [7:0]           in_value,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 q_full,
  output logic                 push,
  output job_t                 job
);

  logic [7:0]      dev_addr_r, dev_reg_r;
  logic [7:0]      frame_addr_r, frame_addr_nxt;
  logic [7:0]      frame_reg_r, frame_reg_nxt;
  logic [FB_W-1:0] fb_r, fb_nxt;
  logic            accept;
  logic            close, open;
  logic [FB_W-1:0] fb_base;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    close          = 1'b0;
    open           = 1'b0;
    push           = 1'b0;
    fb_base        = fb_r;
    fb_nxt         = fb_r;
    frame_addr_nxt = frame_addr_r;
    frame_reg_nxt  = frame_reg_r;
    if (accept) begin
      if (in_command) begin
        if (fb_r != '0) begin
          close  = 1'b1;
          push   = 1'b1;
          fb_nxt = '0;
        end
      end else begin
        close   = (fb_r > FB_LIMIT) ||
                  ((fb_r != '0) && ((frame_addr_r != dev_addr_r) ||
                                    (frame_reg_r != dev_reg_r)));
        fb_base = close ? '0 : fb_r;
        open    = (fb_base == '0);
        push    = 1'b1;
        fb_nxt  = fb_base + (open ? FB_OPEN_ADD : FB_WRITE_ADD);
        if (open) begin
          frame_addr_nxt = dev_addr_r;
          frame_reg_nxt  = dev_reg_r;
        end
      end
    end
  end

  assign job = '{close:     close,
                 open:      open,
                 bank:      in_bank,
                 reg_index: in_reg_index,
                 value:     in_value,
                 hdr_addr:  dev_addr_r,
                 hdr_reg:   dev_reg_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r   <= DEVICE_ADDRESS_RST;
      dev_reg_r    <= DEVICE_REGISTER_RST;
      fb_r         <= '0;
      frame_addr_r <= '0;
      frame_reg_r  <= '0;
    end else begin
      fb_r         <= fb_nxt;
      frame_addr_r <= frame_addr_nxt;
      frame_reg_r  <= frame_reg_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_DEVICE_ADDRESS) begin
          dev_addr_r <= cfg_data;
        end else if (cfg_index == CFG_DEVICE_REGISTER) begin
          dev_reg_r <= cfg_data;
        end
      end
    end
  end

endmodule

@@ rtl/rwsbf_queue.sv @@
`timescale 1ns / 1ps
module rwsbf_queue import rwsbf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output job_t head
);

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/rwsbf_back.sv @@
`timescale 1ns / 1ps
module rwsbf_back import rwsbf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  job_t       head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  back_state_t          state_r, state_nxt, eff;
  logic [CMD_IDX_W-1:0] idx_r, idx_nxt, cur_idx;
  logic [2:0]           lc_r, lc_nxt;
  logic [6:0]           lb_r, lb_nxt;
  logic                 out_valid_r;
  logic [7:0]           out_byte_r;
  logic                 out_last_r;
  logic                 adv, emit, last;
  logic [7:0]           line, cmd;
  logic [14:0]          acc, acc_sh;

  assign adv = !out_valid_r || out_ready;

  // dispatch the queue head in the same cycle the back end goes idle
  always_comb begin
    eff     = state_r;
    cur_idx = idx_r;
    if (state_r == B_IDLE && head_valid) begin
      cur_idx = CMD_SEL;
      if (head.close) begin
        eff = (lc_r != '0) ? B_CLOSE_LO : B_CLOSE_END;
      end else if (head.open) begin
        eff = B_START;
      end else begin
        eff = B_CMD;
      end
    end
  end

  always_comb begin
    unique case (cur_idx)
      CMD_HDR_ADDR: cmd = head.hdr_addr;
      CMD_HDR_REG:  cmd = head.hdr_reg;
      CMD_SEL:      cmd = head.bank ? CMD_SEL_BANK1 : CMD_SEL_BANK0;
      CMD_REG:      cmd = head.reg_index;
      CMD_VAL_SEL:  cmd = head.bank ? CMD_VAL_BANK1 : CMD_VAL_BANK0;
      CMD_VAL:      cmd = head.value;
      CMD_DATA_SEL: cmd = CMD_DATA;
      CMD_DATA_VAL: cmd = head.value;
      default:      cmd = CMD_DATA;
    endcase
  end

  assign acc    = {lb_r, cmd};
  assign acc_sh = acc >> (lc_r + 3'd1);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    lc_nxt    = lc_r;
    lb_nxt    = lb_r;
    emit      = 1'b0;
    last      = 1'b0;
    pop       = 1'b0;
    line      = LINE_END;
    if (adv) begin
      unique case (eff)
        B_IDLE: begin
        end
        B_CLOSE_LO: begin
          emit      = 1'b1;
          line      = line_byte(lb_r);
          state_nxt = B_CLOSE_END;
        end
        B_CLOSE_END: begin
          emit   = 1'b1;
          line   = LINE_END;
          lc_nxt = '0;
          lb_nxt = '0;
          if (head.open) begin
            state_nxt = B_START;
          end else begin
            last      = 1'b1;
            pop       = 1'b1;
            state_nxt = B_IDLE;
          end
        end
        B_START: begin
          emit      = 1'b1;
          line      = LINE_START;
          idx_nxt   = CMD_HDR_ADDR;
          state_nxt = B_CMD;
        end
        B_CMD: begin
          emit    = 1'b1;
          line    = line_byte(acc_sh[6:0]);
          lb_nxt  = cmd[6:0];
          idx_nxt = cur_idx;
          if (lc_r == LC_FULL) begin
            lc_nxt    = '0;
            state_nxt = B_CMD2;
          end else begin
            lc_nxt = lc_r + 3'd1;
            if (cur_idx == CMD_DATA_VAL) begin
              last      = 1'b1;
              pop       = 1'b1;
              state_nxt = B_IDLE;
            end else begin
              idx_nxt   = cur_idx + 1'b1;
              state_nxt = B_CMD;
            end
          end
        end
        B_CMD2: begin
          emit = 1'b1;
          line = line_byte(cmd[6:0]);
          if (cur_idx == CMD_DATA_VAL) begin
            last      = 1'b1;
            pop       = 1'b1;
            state_nxt = B_IDLE;
          end else begin
            idx_nxt   = cur_idx + 1'b1;
            state_nxt = B_CMD;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      idx_r       <= '0;
      lc_r        <= '0;
      lb_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      lc_r    <= lc_nxt;
      lb_r    <= lb_nxt;
      if (adv) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_byte_r <= line;
      out_last_r <= last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

@@ rtl/register_write_seven_bit_framer.sv @@
`timescale 1ns / 1ps
// Sound-chip register write framer. Each write becomes six command bytes
// (eight with the frame header), packed MSB first into seven-bit groups and
// sent as (group << 1) | 1; a frame opens with 0x00. A flush, a full frame
// or a header change closes it with any leftover group and 0x02. The front
// end tracks the frame fill and header and hands jobs through a two-entry
// queue to the back end, which emits one line byte per cycle into the
// output register while out_ready does not stall it. A flush emits no
// bytes when no frame is open. Input transfers continue while the queue
// has room.
module register_write_seven_bit_framer import rwsbf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_command,
  input  logic                 in_bank,
  input  logic [7:0]           in_reg_index,
  input  logic [7:0]           in_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic q_full, push, pop, head_valid;
  job_t job, head;

  rwsbf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_bank      (in_bank),
    .in_reg_index (in_reg_index),
    .in_value     (in_value),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_full       (q_full),
    .push         (push),
    .job          (job)
  );

  rwsbf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  rwsbf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .out_last   (out_last)
  );

endmodule
